/* rtl/cmdq_pkg.sv */
// Shared types and codes for the class matched dispatch queue.
// No dependencies; used by cmdq_if.sv and class_matched_dispatch_queue.sv.
`default_nettype none

package cmdq_pkg;

   localparam int ID_W     = 32;
   localparam int CLASS_W  = 2;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 3;
   localparam int MASK_W   = 3;
   localparam int OCC_W    = 5;

   typedef enum logic [KIND_W-1:0] {
      KIND_ENQUEUE  = 2'd0,
      KIND_READY    = 2'd1,
      KIND_DISPATCH = 2'd2,
      KIND_NONE     = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_QUEUED      = 3'd0,
      ST_FULL        = 3'd1,
      ST_READY_SET   = 3'd2,
      ST_DISPATCHED  = 3'd3,
      ST_NOT_READY   = 3'd4,
      ST_NO_CUSTOMER = 3'd5
   } status_type;

   localparam logic [CLASS_W-1:0] CLASS_NONE = 2'd3;

   typedef struct packed {
      logic [CLASS_W-1:0] cls;
      logic [ID_W-1:0]    id;
   } entry_type;

endpackage

`default_nettype wire

/* rtl/cmdq_if.sv */
// Request and response channel interfaces (valid/ready) of the dispatch queue.
// Depends on cmdq_pkg for field widths.
`default_nettype none

interface cmdq_req_if;
   logic                            valid;
   logic                            ready;
   logic [cmdq_pkg::KIND_W-1:0]     req_type;
   logic [cmdq_pkg::ID_W-1:0]       customer_id;
   logic [cmdq_pkg::CLASS_W-1:0]    product_class;

   modport source (output valid, req_type, customer_id, product_class, input ready);
   modport sink   (input valid, req_type, customer_id, product_class, output ready);
endinterface

interface cmdq_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [cmdq_pkg::STATUS_W-1:0]   status;
   logic [cmdq_pkg::ID_W-1:0]       served_id;
   logic [cmdq_pkg::CLASS_W-1:0]    served_class;
   logic [cmdq_pkg::MASK_W-1:0]     ready_mask;
   logic [cmdq_pkg::OCC_W-1:0]      occupancy;

   modport source (output valid, status, served_id, served_class, ready_mask, occupancy,
                   input ready);
   modport sink   (input valid, status, served_id, served_class, ready_mask, occupancy,
                   output ready);
endinterface

`default_nettype wire

/* rtl/cmdq_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module cmdq_ram #(
   parameter int WIDTH = 34,
   parameter int DEPTH = 16,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/class_matched_dispatch_queue.sv */
// Top level of the class matched dispatch queue: sequencer, tokens, response register.
// Depends on cmdq_pkg, cmdq_if (cmdq_req_if, cmdq_rsp_if) and cmdq_ram.
//
//   channel  dir  fields
//   req      in   req_type, customer_id, product_class
//   rsp      out  status, served_id, served_class, ready_mask, occupancy
//
// Enqueue, ready and not-ready requests pass from accept through S_DECODE to S_REPLY.
// Dispatch walks the entry RAM one read at a time through the class compare and then
// the compaction, which moves each later entry down one slot over the served one.
// Synchronous reset clears state, count, tokens and response valid; RAM contents are not cleared.
// A response waiting on rsp holds; the next request is still accepted meanwhile.
`default_nettype none

module class_matched_dispatch_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   cmdq_req_if.sink  req,
   cmdq_rsp_if.source rsp
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int EW = $bits(cmdq_pkg::entry_type);

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_DECODE  = 7'b0000010,
      S_SCAN_RD = 7'b0000100,
      S_SCAN_CK = 7'b0001000,
      S_MOVE_RD = 7'b0010000,
      S_MOVE_WR = 7'b0100000,
      S_REPLY   = 7'b1000000
   } state_type;

   state_type                          state_ff, state_in;
   logic [CW-1:0]                      count_ff, count_in;
   logic [CW-1:0]                      idx_ff, idx_in;
   logic [cmdq_pkg::MASK_W-1:0]        tokens_ff, tokens_in;
   logic [cmdq_pkg::KIND_W-1:0]        kind_ff, kind_in;
   logic [cmdq_pkg::ID_W-1:0]          id_ff, id_in;
   logic [cmdq_pkg::CLASS_W-1:0]       cls_ff, cls_in;
   cmdq_pkg::status_type               status_ff, status_in;
   logic [cmdq_pkg::ID_W-1:0]          served_ff, served_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [cmdq_pkg::STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [cmdq_pkg::ID_W-1:0]          rsp_id_ff, rsp_id_in;
   logic [cmdq_pkg::CLASS_W-1:0]       rsp_class_ff, rsp_class_in;
   logic [cmdq_pkg::MASK_W-1:0]        rsp_mask_ff, rsp_mask_in;
   logic [cmdq_pkg::OCC_W-1:0]         rsp_occ_ff, rsp_occ_in;

   logic                               wr_en, rd_en;
   logic [AW-1:0]                      wr_addr, rd_addr;
   cmdq_pkg::entry_type                wr_data, rd_data;
   logic [EW-1:0]                      rd_bits;
   logic [cmdq_pkg::MASK_W-1:0]        tok_bit;
   logic                               class_hit;
   logic [CW-1:0]                      idx_next;
   logic                               req_fire, slot_free;

   cmdq_ram #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_bits)
   );

   assign rd_data   = cmdq_pkg::entry_type'(rd_bits);
   assign req.ready = (state_ff == S_IDLE);
   assign req_fire  = req.valid && req.ready;
   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign tok_bit   = (cls_ff == cmdq_pkg::CLASS_NONE) ? '0
                      : cmdq_pkg::MASK_W'(3'b001 << cls_ff);
   assign class_hit = (rd_data.cls == cls_ff);
   assign idx_next  = idx_ff + 1'b1;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      tokens_in     = tokens_ff;
      kind_in       = kind_ff;
      id_in         = id_ff;
      cls_in        = cls_ff;
      status_in     = status_ff;
      served_in     = served_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_class_in  = rsp_class_ff;
      rsp_mask_in   = rsp_mask_ff;
      rsp_occ_in    = rsp_occ_ff;
      wr_en         = 1'b0;
      wr_addr       = AW'(count_ff);
      wr_data       = '{cls: cls_ff, id: id_ff};
      rd_en         = 1'b0;
      rd_addr       = AW'(idx_ff);

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               kind_in  = req.req_type;
               id_in    = req.customer_id;
               cls_in   = req.product_class;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            served_in = '0;
            state_in  = S_REPLY;
            case (kind_ff)
               cmdq_pkg::KIND_ENQUEUE: begin
                  if (count_ff == CW'(QUEUE_DEPTH)) begin
                     status_in = cmdq_pkg::ST_FULL;
                  end else begin
                     wr_en     = 1'b1;
                     count_in  = count_ff + 1'b1;
                     status_in = cmdq_pkg::ST_QUEUED;
                  end
               end
               cmdq_pkg::KIND_READY: begin
                  tokens_in = tokens_ff | tok_bit;
                  status_in = cmdq_pkg::ST_READY_SET;
               end
               cmdq_pkg::KIND_DISPATCH: begin
                  if ((tokens_ff & tok_bit) == '0) begin
                     status_in = cmdq_pkg::ST_NOT_READY;
                  end else begin
                     tokens_in = tokens_ff & ~tok_bit;
                     idx_in    = '0;
                     if (count_ff == '0) begin
                        status_in = cmdq_pkg::ST_NO_CUSTOMER;
                     end else begin
                        state_in = S_SCAN_RD;
                     end
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_SCAN_RD: begin
            rd_en    = 1'b1;
            state_in = S_SCAN_CK;
         end
         S_SCAN_CK: begin
            idx_in = idx_next;
            if (class_hit) begin
               served_in = rd_data.id;
               state_in  = S_MOVE_RD;
            end else if (idx_next == count_ff) begin
               status_in = cmdq_pkg::ST_NO_CUSTOMER;
               state_in  = S_REPLY;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_MOVE_RD: begin
            if (idx_ff == count_ff) begin
               count_in  = count_ff - 1'b1;
               status_in = cmdq_pkg::ST_DISPATCHED;
               state_in  = S_REPLY;
            end else begin
               rd_en    = 1'b1;
               state_in = S_MOVE_WR;
            end
         end
         S_MOVE_WR: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(idx_ff - 1'b1);
            wr_data  = rd_data;
            idx_in   = idx_next;
            state_in = S_MOVE_RD;
         end
         S_REPLY: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_id_in     = served_ff;
               rsp_class_in  = cls_ff;
               rsp_mask_in   = tokens_ff;
               rsp_occ_in    = cmdq_pkg::OCC_W'(count_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         tokens_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         tokens_ff    <= tokens_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      kind_ff       <= kind_in;
      id_ff         <= id_in;
      cls_ff        <= cls_in;
      status_ff     <= status_in;
      served_ff     <= served_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_class_ff  <= rsp_class_in;
      rsp_mask_ff   <= rsp_mask_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.served_id    = rsp_id_ff;
   assign rsp.served_class = rsp_class_ff;
   assign rsp.ready_mask   = rsp_mask_ff;
   assign rsp.occupancy    = rsp_occ_ff;

endmodule

`default_nettype wire
